// ----- rtl/m3i_pkg.sv -----
// Shared constants and types of the 3x3 matrix inverse block.
package m3i_pkg;

  localparam int FracBits = 16;
  localparam int ElemW    = 32;
  localparam int NumElem  = 9;
  localparam int AdjW     = 2 * ElemW + 1;       // signed cofactor width
  localparam int DetW     = ElemW + AdjW + 2;    // signed determinant width
  localparam int ThrW     = 62;
  localparam int QBits    = ElemW + 1;           // quotient bits kept before saturation
  localparam int QDepth   = 2;

  localparam logic [ThrW-1:0]  ThrReset = 62'd2814749767;
  localparam logic [ElemW-1:0] SatMax   = 32'h7FFF_FFFF;
  localparam logic [ElemW-1:0] SatMin   = 32'h8000_0000;
  localparam logic [QBits-1:0] NegLimit = 33'h0_8000_0000;

  typedef logic [NumElem-1:0][ElemW-1:0] mat_t;

  // One classified matrix handed from front to back.
  typedef struct packed {
    logic                           singular;
    mat_t                           mat;
    logic [NumElem-1:0][AdjW-1:0]   mag_adj;
    logic [DetW-1:0]                mag_det;
    logic [NumElem-1:0]             neg;
    logic [NumElem-1:0]             ovf;
  } item_t;

  typedef struct packed {
    logic not_empty;
    logic full;
  } q_stat_t;

endpackage

// ----- rtl/m3i_front.sv -----
// Front pipeline: accepts matrices, forms adjugate and determinant, classifies.
module m3i_front #(
  parameter int FRAC_BITS = m3i_pkg::FracBits
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic                                adv_i,
  input  logic signed [m3i_pkg::ElemW-1:0]    a_i [m3i_pkg::NumElem],
  input  logic                                cfg_valid_i,
  input  logic [m3i_pkg::ThrW-1:0]            cfg_data_i,
  output logic                                push_o,
  output m3i_pkg::item_t                      item_o
);

  localparam int EW = m3i_pkg::ElemW;
  localparam int NE = m3i_pkg::NumElem;
  localparam int AW = m3i_pkg::AdjW;
  localparam int DW = m3i_pkg::DetW;
  localparam int QB = m3i_pkg::QBits;
  localparam int NW = AW + 2 * FRAC_BITS;
  localparam int CW = ((NW > DW + QB) ? NW : DW + QB) + 1;

  localparam int CofP [NE] = '{4, 7, 1, 6, 0, 3, 3, 6, 0};
  localparam int CofQ [NE] = '{8, 2, 5, 5, 8, 2, 7, 1, 4};
  localparam int CofR [NE] = '{7, 1, 4, 3, 6, 0, 6, 0, 3};
  localparam int CofS [NE] = '{5, 8, 2, 8, 2, 5, 4, 7, 1};
  localparam int DetA [3]  = '{0, 3, 6};

  logic [m3i_pkg::ThrW-1:0] thr_q;
  logic [7:0]               v_q;

  logic signed [EW-1:0]   a1_q [NE], a2_q [NE], a3_q [NE], a4_q [NE];
  logic signed [EW-1:0]   a5_q [NE], a6_q [NE], a7_q [NE];
  logic signed [2*EW-1:0] pp_q [NE], pn_q [NE];
  logic signed [AW-1:0]   adj3_q [NE], adj4_q [NE], adj5_q [NE], adj6_q [NE];
  logic signed [EW+EW:0]  lo_q [3], hi_q [3];
  logic signed [DW-1:0]   t_q [3];
  logic signed [DW-1:0]   det_q;
  logic [AW-1:0]          madj_q [NE];
  logic [DW-1:0]          mdet_q;
  logic [NE-1:0]          neg_q;
  m3i_pkg::item_t         item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= m3i_pkg::ThrReset;
    end else if (cfg_valid_i) begin
      thr_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv_i) begin
      v_q <= {v_q[6:0], start_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int i = 0; i < NE; i++) begin
        a1_q[i] <= a_i[i];
        a2_q[i] <= a1_q[i];
        pp_q[i] <= a1_q[CofP[i]] * a1_q[CofQ[i]];
        pn_q[i] <= a1_q[CofR[i]] * a1_q[CofS[i]];
        a3_q[i] <= a2_q[i];
        adj3_q[i] <= AW'(pp_q[i]) - AW'(pn_q[i]);
        a4_q[i] <= a3_q[i];
        adj4_q[i] <= adj3_q[i];
        a5_q[i] <= a4_q[i];
        adj5_q[i] <= adj4_q[i];
        a6_q[i] <= a5_q[i];
        adj6_q[i] <= adj5_q[i];
        a7_q[i] <= a6_q[i];
        madj_q[i] <= adj6_q[i][AW-1] ? AW'(-adj6_q[i]) : AW'(adj6_q[i]);
      end
      // split each 32 x 65 product into two narrow partial products
      for (int j = 0; j < 3; j++) begin
        lo_q[j] <= a3_q[j] * $signed({1'b0, adj3_q[DetA[j]][EW-1:0]});
        hi_q[j] <= a3_q[j] * $signed(adj3_q[DetA[j]][AW-1:EW]);
        t_q[j]  <= (DW'(hi_q[j]) <<< EW) + DW'(lo_q[j]);
      end
      det_q  <= t_q[0] + t_q[1] + t_q[2];
      mdet_q <= det_q[DW-1] ? DW'(-det_q) : DW'(det_q);
      for (int i = 0; i < NE; i++) begin
        neg_q[i] <= adj6_q[i][AW-1] ^ det_q[DW-1];
      end
      item_q.singular <= mdet_q <= DW'(thr_q);
      item_q.mag_det  <= mdet_q;
      item_q.neg      <= neg_q;
      for (int i = 0; i < NE; i++) begin
        item_q.mat[i]     <= a7_q[i];
        item_q.mag_adj[i] <= madj_q[i];
        // quotient would need more than QB bits: saturate
        item_q.ovf[i] <= (CW'(madj_q[i]) << (2 * FRAC_BITS)) >= (CW'(mdet_q) << QB);
      end
    end
  end

  assign push_o = v_q[7] && adv_i;
  assign item_o = item_q;

endmodule

// ----- rtl/m3i_queue.sv -----
// Short queue of classified matrices between front and back.
module m3i_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  m3i_pkg::item_t     item_i,
  input  logic               pop_i,
  output m3i_pkg::item_t     head_o,
  output m3i_pkg::q_stat_t   stat_o
);

  localparam int Depth = m3i_pkg::QDepth;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  m3i_pkg::item_t  mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= PtrW'((32'(wr_q) + 1) % Depth);
      if (pop_i)  rd_q <= PtrW'((32'(rd_q) + 1) % Depth);
      cnt_q <= cnt_q + CntW'(push_i) - CntW'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= item_i;
  end

  assign head_o           = mem_q[rd_q];
  assign stat_o.not_empty = cnt_q != '0;
  assign stat_o.full      = cnt_q == CntW'(Depth);

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth)) else $error("queue count beyond depth");
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!stat_o.full || pop_i)) else $error("push into full queue");
  a_no_underrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> stat_o.not_empty) else $error("pop from empty queue");
  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> cnt_q == $past(cnt_q) + CntW'(1)) else $error("count lost a beat");

endmodule

// ----- rtl/m3i_div_lane.sv -----
// One pipelined restoring divider lane with saturation to 32 bits.
module m3i_div_lane #(
  parameter int FRAC_BITS = m3i_pkg::FracBits
) (
  input  logic                          clk_i,
  input  logic [m3i_pkg::AdjW-1:0]      mag_adj_i,
  input  logic [m3i_pkg::DetW-1:0]      mag_det_i,
  input  logic                          neg_i,
  input  logic                          ovf_i,
  output logic [m3i_pkg::ElemW-1:0]     res_o
);

  localparam int QB = m3i_pkg::QBits;
  localparam int DW = m3i_pkg::DetW;
  localparam int RW = DW + 1;
  localparam int NW = m3i_pkg::AdjW + 2 * FRAC_BITS;
  localparam int EW = m3i_pkg::ElemW;

  logic [NW-1:0] num;
  logic [RW-1:0] r_q   [QB];
  logic [QB-1:0] l_q   [QB];
  logic [QB-1:0] q_q   [QB+1];
  logic [DW-1:0] d_q   [QB];
  logic          neg_q [QB+1];
  logic          ovf_q [QB+1];

  assign num = NW'(mag_adj_i) << (2 * FRAC_BITS);

  always_ff @(posedge clk_i) begin
    r_q[0]   <= RW'(num >> QB);
    l_q[0]   <= num[QB-1:0];
    q_q[0]   <= '0;
    d_q[0]   <= mag_det_i;
    neg_q[0] <= neg_i;
    ovf_q[0] <= ovf_i;
  end

  for (genvar k = 1; k <= QB; k++) begin : g_step
    logic [RW-1:0] rs;
    logic          ge;
    assign rs = {r_q[k-1][RW-2:0], l_q[k-1][QB-1]};
    assign ge = rs >= {1'b0, d_q[k-1]};
    always_ff @(posedge clk_i) begin
      q_q[k]   <= {q_q[k-1][QB-2:0], ge};
      neg_q[k] <= neg_q[k-1];
      ovf_q[k] <= ovf_q[k-1];
    end
    if (k < QB) begin : g_carry
      always_ff @(posedge clk_i) begin
        r_q[k] <= ge ? rs - {1'b0, d_q[k-1]} : rs;
        l_q[k] <= {l_q[k-1][QB-2:0], 1'b0};
        d_q[k] <= d_q[k-1];
      end
    end
  end

  always_comb begin
    if (neg_q[QB]) begin
      res_o = (ovf_q[QB] || q_q[QB] > m3i_pkg::NegLimit) ? m3i_pkg::SatMin
                                                         : EW'(-q_q[QB][EW-1:0]);
    end else begin
      res_o = (ovf_q[QB] || q_q[QB][QB-1] || q_q[QB][EW-1]) ? m3i_pkg::SatMax
                                                            : q_q[QB][EW-1:0];
    end
  end

endmodule

// ----- rtl/m3i_back.sv -----
// Back part: nine divider lanes, bypass for singular matrices, result register.
module m3i_back #(
  parameter int FRAC_BITS = m3i_pkg::FracBits
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  m3i_pkg::item_t              item_i,
  output logic                        done_o,
  output logic                        singular_o,
  output m3i_pkg::mat_t               res_o
);

  localparam int QB = m3i_pkg::QBits;
  localparam int NE = m3i_pkg::NumElem;

  logic [QB:0]    vld_q;
  logic           sing_q [QB+1];
  m3i_pkg::mat_t  mat_q  [QB+1];
  m3i_pkg::mat_t  lane_res;
  logic           done_q, singular_q;
  m3i_pkg::mat_t  res_q;

  for (genvar i = 0; i < NE; i++) begin : g_lane
    m3i_div_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
      .clk_i     (clk_i),
      .mag_adj_i (item_i.mag_adj[i]),
      .mag_det_i (item_i.mag_det),
      .neg_i     (item_i.neg[i]),
      .ovf_i     (item_i.ovf[i]),
      .res_o     (lane_res[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      done_q <= 1'b0;
    end else begin
      vld_q  <= {vld_q[QB-1:0], valid_i};
      done_q <= vld_q[QB];
    end
  end

  always_ff @(posedge clk_i) begin
    sing_q[0] <= item_i.singular;
    mat_q[0]  <= item_i.mat;
    for (int k = 1; k <= QB; k++) begin
      sing_q[k] <= sing_q[k-1];
      mat_q[k]  <= mat_q[k-1];
    end
    singular_q <= sing_q[QB];
    res_q      <= sing_q[QB] ? mat_q[QB] : lane_res;
  end

  assign done_o     = done_q;
  assign singular_o = singular_q;
  assign res_o      = res_q;

endmodule

// ----- rtl/matrix3x3_inverse.sv -----
// Top level of the 3x3 matrix inverse block.
//
//  channel   direction  handshake                 beat
//  command   in         start & !busy             a00_i .. a22_i
//  result    out        done_o, one cycle         r00_o .. r22_o, singular_o
//  config    in         cfg_valid_i & cfg_ready_o cfg_data_i (det_threshold)
//
// One matrix enters every cycle.
// Each result passes through an 8-stage front, the queue and the 33-step pipelined divider lanes.
// The queue drains every cycle, so it never fills and busy stays low; the back never stalls.
// Reset clears the pipeline valids and the queue and loads the default threshold.
module matrix3x3_inverse #(
  parameter int FRAC_BITS = m3i_pkg::FracBits
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [m3i_pkg::ElemW-1:0]       a00_i, a01_i, a02_i,
  input  logic [m3i_pkg::ElemW-1:0]       a10_i, a11_i, a12_i,
  input  logic [m3i_pkg::ElemW-1:0]       a20_i, a21_i, a22_i,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [m3i_pkg::ThrW-1:0]        cfg_data_i,
  output logic                            done_o,
  output logic [m3i_pkg::ElemW-1:0]       r00_o, r01_o, r02_o,
  output logic [m3i_pkg::ElemW-1:0]       r10_o, r11_o, r12_o,
  output logic [m3i_pkg::ElemW-1:0]       r20_o, r21_o, r22_o,
  output logic                            singular_o
);

  logic signed [m3i_pkg::ElemW-1:0] a_in [m3i_pkg::NumElem];
  logic                             adv, push, pop;
  m3i_pkg::item_t                   f_item, q_head;
  m3i_pkg::q_stat_t                 q_stat;
  m3i_pkg::mat_t                    res;

  assign a_in = '{a00_i, a01_i, a02_i, a10_i, a11_i, a12_i, a20_i, a21_i, a22_i};

  // drain the queue every cycle; hold the front only on a full queue
  assign pop         = q_stat.not_empty;
  assign adv         = !q_stat.full || pop;
  assign busy        = !adv;
  assign cfg_ready_o = 1'b1;

  m3i_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .adv_i       (adv),
    .a_i         (a_in),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .push_o      (push),
    .item_o      (f_item)
  );

  m3i_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (f_item),
    .pop_i  (pop),
    .head_o (q_head),
    .stat_o (q_stat)
  );

  m3i_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (pop),
    .item_i     (q_head),
    .done_o     (done_o),
    .singular_o (singular_o),
    .res_o      (res)
  );

  assign r00_o = res[0];
  assign r01_o = res[1];
  assign r02_o = res[2];
  assign r10_o = res[3];
  assign r11_o = res[4];
  assign r12_o = res[5];
  assign r20_o = res[6];
  assign r21_o = res[7];
  assign r22_o = res[8];

endmodule

// ----- bench/m3i_checker.sv -----
// Predicts each inverse from the accepted matrices and compares it with the block's results.
`timescale 1ns / 100ps
module m3i_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  input  logic                              busy,
  input  m3i_pkg::mat_t                     mat_i,
  input  logic                              cfg_valid_i,
  input  logic                              cfg_ready_i,
  input  logic [m3i_pkg::ThrW-1:0]          cfg_data_i,
  input  logic                              done_i,
  input  m3i_pkg::mat_t                     inv_i,
  input  logic                              singular_i,
  output int                                fail_count_o,
  output int                                pending_o
);

  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    m3i_pkg::mat_t inv;
    logic          singular;
  } inverse_t;

  logic [m3i_pkg::ThrW-1:0] threshold_q;
  inverse_t                 inverse_q[$];
  int                       fails;

  assign fail_count_o = fails;
  assign pending_o    = inverse_q.size();

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
    fails++;
  endtask

  function automatic logic [m3i_pkg::ElemW-1:0] sat_divide(input wide_t adj,
                                                           input wide_t det);
    logic  neg;
    wide_t num;
    wide_t q;
    neg = (adj < 0) != (det < 0);
    num = (adj < 0 ? -adj : adj) << (2 * m3i_pkg::FracBits);
    q   = $unsigned(num) / $unsigned(det < 0 ? -det : det);
    if (neg) begin
      if ($unsigned(q) > 128'h8000_0000) return m3i_pkg::SatMin;
      return -q[m3i_pkg::ElemW-1:0];
    end
    if ($unsigned(q) > 128'h7FFF_FFFF) return m3i_pkg::SatMax;
    return q[m3i_pkg::ElemW-1:0];
  endfunction

  function automatic inverse_t invert(input m3i_pkg::mat_t m,
                                      input logic [m3i_pkg::ThrW-1:0] thr);
    wide_t    a[9];
    wide_t    adj[9];
    wide_t    det;
    wide_t    mag;
    inverse_t res;
    for (int i = 0; i < 9; i++) a[i] = wide_t'($signed(m[i]));
    adj[0] = a[4] * a[8] - a[7] * a[5];
    adj[1] = a[7] * a[2] - a[1] * a[8];
    adj[2] = a[1] * a[5] - a[4] * a[2];
    adj[3] = a[6] * a[5] - a[3] * a[8];
    adj[4] = a[0] * a[8] - a[6] * a[2];
    adj[5] = a[3] * a[2] - a[0] * a[5];
    adj[6] = a[3] * a[7] - a[6] * a[4];
    adj[7] = a[6] * a[1] - a[0] * a[7];
    adj[8] = a[0] * a[4] - a[3] * a[1];
    det = a[0] * adj[0] + a[1] * adj[3] + a[2] * adj[6];
    mag = det < 0 ? -det : det;
    if ($unsigned({66'b0, thr}) >= $unsigned(mag)) begin
      res.inv      = m;
      res.singular = 1'b1;
    end else begin
      for (int i = 0; i < 9; i++) res.inv[i] = sat_divide(adj[i], det);
      res.singular = 1'b0;
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    inverse_t want;
    if (!rst_ni) begin
      threshold_q <= m3i_pkg::ThrReset;
      inverse_q.delete();
      fails = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) threshold_q <= cfg_data_i;
      if (start && !busy) inverse_q.push_back(invert(mat_i, threshold_q));
      if (done_i) begin
        if (inverse_q.size() == 0) begin
          report_mismatch("unexpected result beat", 32'd1, 32'd0);
        end else begin
          want = inverse_q.pop_front();
          for (int i = 0; i < 9; i++)
            if (inv_i[i] !== want.inv[i])
              report_mismatch($sformatf("r%0d%0d", i / 3, i % 3), inv_i[i], want.inv[i]);
          if (singular_i !== want.singular)
            report_mismatch("singular", 32'(singular_i), 32'(want.singular));
        end
      end
    end
  end
endmodule

// ----- bench/testbench.sv -----
// Drives matrices and threshold writes into the 3x3 matrix inverse block and gives the verdict.
`timescale 1ns / 100ps
module testbench;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     start;
  logic                     busy;
  m3i_pkg::mat_t            mat_q;
  m3i_pkg::mat_t            inv;
  logic                     cfg_valid_i;
  logic                     cfg_ready_o;
  logic [m3i_pkg::ThrW-1:0] cfg_data_i;
  logic                     done_o;
  logic                     singular_o;
  int                       fail_count;
  int                       pending;
  int                       idle_pct;

  matrix3x3_inverse DUT (
    .clk_i, .rst_ni, .start, .busy,
    .a00_i(mat_q[0]), .a01_i(mat_q[1]), .a02_i(mat_q[2]),
    .a10_i(mat_q[3]), .a11_i(mat_q[4]), .a12_i(mat_q[5]),
    .a20_i(mat_q[6]), .a21_i(mat_q[7]), .a22_i(mat_q[8]),
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i, .done_o,
    .r00_o(inv[0]), .r01_o(inv[1]), .r02_o(inv[2]),
    .r10_o(inv[3]), .r11_o(inv[4]), .r12_o(inv[5]),
    .r20_o(inv[6]), .r21_o(inv[7]), .r22_o(inv[8]),
    .singular_o
  );

  m3i_checker u_checker (
    .clk_i, .rst_ni, .start, .busy, .mat_i(mat_q), .cfg_valid_i,
    .cfg_ready_i(cfg_ready_o), .cfg_data_i, .done_i(done_o), .inv_i(inv),
    .singular_i(singular_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("matrix3x3_inverse regression: fail");
    $finish;
  end

  // Hold start across back-to-back beats; drop it only for an idle gap.
  task automatic send_matrix(input m3i_pkg::mat_t m);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    mat_q <= m;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic write_threshold(input logic [m3i_pkg::ThrW-1:0] thr);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= thr;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic m3i_pkg::mat_t diag(input logic [31:0] d0, input logic [31:0] d1,
                                         input logic [31:0] d2);
    m3i_pkg::mat_t m;
    m    = '0;
    m[0] = d0;
    m[4] = d1;
    m[8] = d2;
    return m;
  endfunction

  function automatic m3i_pkg::mat_t rand_matrix();
    m3i_pkg::mat_t m;
    int            kind;
    kind = $urandom_range(9);
    for (int i = 0; i < 9; i++) m[i] = $urandom();
    if (kind < 5) begin
      // well conditioned: dominant diagonal near unit scale
      for (int i = 0; i < 9; i++)
        m[i] = (i % 4 == 0) ? 32'($urandom_range(32768, 262144)) * ($urandom_range(1) ? 1 : -1)
                            : 32'(int'($urandom_range(65535)) - 32768);
    end else if (kind < 7) begin
      // near singular: last row copies the first, slightly perturbed
      for (int i = 0; i < 9; i++) m[i] = 32'(int'($urandom_range(2000000)) - 1000000);
      for (int i = 0; i < 3; i++) m[6 + i] = m[i] + 32'(int'($urandom_range(4)) - 2);
    end else if (kind == 7) begin
      // tiny elements, determinant around the threshold
      for (int i = 0; i < 9; i++) m[i] = 32'(int'($urandom_range(4096)) - 2048);
    end
    return m;
  endfunction

  task automatic directed();
    m3i_pkg::mat_t m;
    send_matrix(diag(32'h1_0000, 32'h1_0000, 32'h1_0000));
    send_matrix('0);
    send_matrix(diag(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_matrix(diag(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    send_matrix(diag(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
    send_matrix(diag(32'h1, 32'h1_0000, 32'h1_0000));
    send_matrix(diag(32'hFFFF_FFFF, 32'h1_0000, 32'h1_0000));
    send_matrix(diag(32'h100, 32'h100, 32'h100));
    send_matrix(diag(32'h2_0000, 32'hFFFE_0000, 32'h4_0000));
    send_matrix('1);
    for (int i = 0; i < 9; i++) m[i] = (i % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    send_matrix(m);
    for (int i = 0; i < 9; i++) m[i] = 32'((i + 1) << 16);
    send_matrix(m);
    m = diag(32'h1_0000, 32'h1_0000, 32'h1_0000);
    m[2] = 32'h7FFF_FFFF;
    m[6] = 32'h8000_0000;
    send_matrix(m);
  endtask

  initial begin
    rst_ni      <= 1'b0;
    start       <= 1'b0;
    mat_q       <= '0;
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= '0;
    idle_pct    = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed();
    write_threshold('0);
    directed();
    write_threshold({m3i_pkg::ThrW{1'b1}});
    directed();
    write_threshold(m3i_pkg::ThrReset);

    idle_pct = 8;
    repeat (400) send_matrix(rand_matrix());
    write_threshold(62'(64'($urandom()) << $urandom_range(40)));
    repeat (50) send_matrix(rand_matrix());
    drain();
    idle_pct = 77;
    repeat (350) send_matrix(rand_matrix());
    write_threshold('0);
    idle_pct = 0;
    repeat (300) send_matrix(rand_matrix());
    write_threshold(62'({$urandom(), $urandom()}));
    repeat (100) send_matrix(rand_matrix());

    drain();
    if (fail_count == 0) begin
      $display("matrix3x3_inverse regression: pass");
    end else begin
      $display("matrix3x3_inverse regression: fail");
    end
    $finish;
  end
endmodule
